// ===== rtl/core/sset_pkg.sv =====
// Shared types and constants for the sorted set engine.
package sset_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int KEY_FIELD_W   = 32;
    localparam int RANK_FIELD_W  = 4;
    localparam int COUNT_FIELD_W = 5;

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_ERASE    = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_GET      = 2'd3
    } sset_mode_t;

    typedef struct packed {
        sset_mode_t                mode;
        logic [KEY_FIELD_W-1:0]    key;
        logic [RANK_FIELD_W-1:0]   rank;
    } sset_req_t;

    typedef struct packed {
        logic                      success;
        logic                      full_res;
        logic [KEY_FIELD_W-1:0]    key_out;
        logic [COUNT_FIELD_W-1:0]  count;
    } sset_rsp_t;

    // Broadcast to every cell: which shift, if any, happens this cycle.
    typedef struct packed {
        logic ins;
        logic del;
    } sset_ctl_t;

endpackage

// ===== rtl/core/sset_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface sset_req_if;
    import sset_pkg::*;

    logic      valid;
    logic      ready;
    sset_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sset_rsp_if;
    import sset_pkg::*;

    logic      valid;
    logic      ready;
    sset_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sset_cell.sv =====
// One storage cell of the sorted chain: compare with the broadcast key, shift.
module sset_cell #(
    parameter int KEY_WIDTH = sset_pkg::KEY_WIDTH_DEF
) (
    input  logic                 clk,
    input  sset_pkg::sset_ctl_t  ctl,
    input  logic [KEY_WIDTH-1:0] bkey,
    input  logic                 occupied,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic                 left_lt,
    input  logic [KEY_WIDTH-1:0] right_key,
    output logic [KEY_WIDTH-1:0] key_q,
    output logic                 lt,
    output logic                 eq
);
    import sset_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    assign lt    = occupied && (key_reg < bkey);
    assign eq    = occupied && (key_reg == bkey);
    assign key_q = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins && !lt)
        begin
            // first cell not below the key takes it, the rest move up
            if (left_lt)
            begin
                key_next = bkey;
            end
            else
            begin
                key_next = left_key;
            end
        end
        else if (ctl.del && !lt)
        begin
            // close the gap from the right
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== rtl/core/sset_chain.sv =====
// Row of cells with neighbour wiring, match detection and rank readout.
module sset_chain #(
    parameter int CAPACITY  = sset_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = sset_pkg::KEY_WIDTH_DEF,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int RW       = (CNT_W > sset_pkg::RANK_FIELD_W) ? CNT_W
                                                               : sset_pkg::RANK_FIELD_W
) (
    input  logic                 clk,
    input  sset_pkg::sset_ctl_t  ctl,
    input  logic [KEY_WIDTH-1:0] bkey,
    input  logic [CNT_W-1:0]     count,
    input  logic [RW-1:0]        rank_sel,
    output logic                 found,
    output logic [KEY_WIDTH-1:0] rd_key
);
    import sset_pkg::*;

    logic [KEY_WIDTH-1:0] key_q [CAPACITY];
    logic [CAPACITY-1:0]  lt_vec;
    logic [CAPACITY-1:0]  eq_vec;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] left_key;
        logic                 left_lt;
        logic [KEY_WIDTH-1:0] right_key;

        if (i == 0)
        begin : g_first
            assign left_key = bkey;
            assign left_lt  = 1'b1;
        end
        else
        begin : g_mid
            assign left_key = key_q[i-1];
            assign left_lt  = lt_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = bkey;
        end
        else
        begin : g_inner
            assign right_key = key_q[i+1];
        end

        sset_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .bkey      (bkey),
            .occupied  (count > CNT_W'(i)),
            .left_key  (left_key),
            .left_lt   (left_lt),
            .right_key (right_key),
            .key_q     (key_q[i]),
            .lt        (lt_vec[i]),
            .eq        (eq_vec[i])
        );
    end

    assign found = |eq_vec;

    always_comb
    begin
        rd_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (RW'(i) == rank_sel)
            begin
                rd_key = rd_key | key_q[i];
            end
        end
    end

endmodule

// ===== rtl/core/sorted_set_engine_unit.sv =====
// Sorted set engine top level: request decode, count, result register.
//
//   channel  dir  payload                          transfer
//   req      in   mode, key, rank                  req.valid && req.ready
//   rsp      out  success, full_res, key_out, count rsp.valid && rsp.ready
//
// One request is taken per cycle while req.ready is high, and its result is registered for the next cycle;
// every cell compares with the broadcast key and shifts in the cycle the request is taken.
// A pending result that is not taken holds rsp and blocks req until the
// transfer; taking it frees req in the same cycle.
// Reset empties the set at once (count zero); cell contents need no clearing.
module sorted_set_engine_unit #(
    parameter int CAPACITY  = sset_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = sset_pkg::KEY_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sset_req_if.sink   req,
    sset_rsp_if.source rsp
);
    import sset_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int RW    = (CNT_W > RANK_FIELD_W) ? CNT_W : RANK_FIELD_W;

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         rsp_valid_reg;
    sset_rsp_t                    rsp_reg;
    sset_rsp_t                    rsp_next;

    logic                         accept;
    logic                         found;
    logic                         full;
    logic                         rank_ok;
    sset_ctl_t                    ctl;
    logic [KEY_WIDTH+KEY_FIELD_W-1:0] key_in_wide;
    logic [KEY_WIDTH-1:0]         bkey;
    logic [RW-1:0]                rank_x;
    logic [RW-1:0]                count_x;
    logic [KEY_WIDTH-1:0]         rd_key;
    logic [KEY_WIDTH+KEY_FIELD_W-1:0] key_out_wide;
    logic [CNT_W+COUNT_FIELD_W-1:0]   count_wide;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // compare on the low KEY_WIDTH bits only
    assign key_in_wide = (KEY_WIDTH + KEY_FIELD_W)'(req.payload.key);
    assign bkey        = key_in_wide[KEY_WIDTH-1:0];

    assign rank_x  = RW'(req.payload.rank);
    assign count_x = RW'(count_reg);
    assign rank_ok = rank_x < count_x;
    assign full    = count_reg == CNT_W'(CAPACITY);

    assign ctl.ins = accept && (req.payload.mode == MODE_INSERT) && !found && !full;
    assign ctl.del = accept && (req.payload.mode == MODE_ERASE) && found;

    sset_chain #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_chain (
        .clk      (clk),
        .ctl      (ctl),
        .bkey     (bkey),
        .count    (count_reg),
        .rank_sel (rank_x),
        .found    (found),
        .rd_key   (rd_key)
    );

    assign key_out_wide = (KEY_WIDTH + KEY_FIELD_W)'(rd_key);

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_wide = (CNT_W + COUNT_FIELD_W)'(count_next);

    always_comb
    begin
        rsp_next          = '0;
        rsp_next.count    = count_wide[COUNT_FIELD_W-1:0];
        case (req.payload.mode)
            MODE_INSERT:
            begin
                rsp_next.success  = ctl.ins;
                rsp_next.full_res = !found && full;
            end
            MODE_ERASE:
            begin
                rsp_next.success = found;
            end
            MODE_CONTAINS:
            begin
                rsp_next.success = found;
            end
            MODE_GET:
            begin
                rsp_next.success = rank_ok;
                if (rank_ok)
                begin
                    rsp_next.key_out = key_out_wide[KEY_FIELD_W-1:0];
                end
            end
            default:
            begin
                rsp_next.success = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on each request transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the sorted set engine: directed table, then random traffic.
module tb;
    import sset_pkg::*;

    localparam int          CAP      = CAPACITY_DEF;
    localparam logic [31:0] KEY_MASK = (KEY_WIDTH_DEF >= 32) ? 32'hFFFF_FFFF
                                                             : (32'h1 << KEY_WIDTH_DEF) - 1;
    localparam int          N_RANDOM = 650;

    typedef struct {
        sset_req_t rq;
        bit        fixed;
        sset_rsp_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sset_req_if req_ch ();
    sset_rsp_if rsp_ch ();

    sorted_set_engine_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the set
    logic [31:0] set_keys [CAP];
    int unsigned set_count;

    sset_rsp_t   pending_results [$];
    stim_row_t   stim_tab [$];
    logic [31:0] key_pool [24];
    int          mismatches;
    bit          calm;
    int          rcv_hold;
    bit          offer_fixed;
    sset_rsp_t   offer_want;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

    // Apply one operation to the shadow set and return its result.
    function automatic sset_rsp_t set_apply(sset_req_t rq);
        logic [31:0] k;
        int unsigned pos;
        int unsigned i;
        bit          hit;
        sset_rsp_t   res;
        k   = rq.key & KEY_MASK;
        pos = 0;
        while (pos < set_count && set_keys[pos] < k)
            pos++;
        hit = (pos < set_count) && (set_keys[pos] == k);
        res = '0;
        case (rq.mode)
            MODE_INSERT:
            begin
                if (!hit)
                begin
                    if (set_count >= CAP)
                        res.full_res = 1'b1;
                    else
                    begin
                        for (i = set_count; i > pos; i--)
                            set_keys[i] = set_keys[i-1];
                        set_keys[pos] = k;
                        set_count++;
                        res.success = 1'b1;
                    end
                end
            end
            MODE_ERASE:
            begin
                if (hit)
                begin
                    for (i = pos; i + 1 < set_count; i++)
                        set_keys[i] = set_keys[i+1];
                    set_count--;
                    res.success = 1'b1;
                end
            end
            MODE_CONTAINS:
                res.success = hit;
            default:
            begin
                if (rq.rank < set_count)
                begin
                    res.key_out = set_keys[rq.rank];
                    res.success = 1'b1;
                end
            end
        endcase
        res.count = COUNT_FIELD_W'(set_count);
        return res;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int w;
        w = $urandom_range(0, 99);
        if (calm || w < 60)
            return 0;
        else if (w < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic sset_req_t make_op(bit fill);
        sset_req_t rq;
        int        w;
        w = $urandom_range(0, 99);
        if (fill)
            rq.mode = (w < 55) ? MODE_INSERT : (w < 70) ? MODE_ERASE :
                      (w < 85) ? MODE_CONTAINS : MODE_GET;
        else
            rq.mode = (w < 15) ? MODE_INSERT : (w < 60) ? MODE_ERASE :
                      (w < 80) ? MODE_CONTAINS : MODE_GET;
        rq.key  = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 23)] : $urandom;
        rq.rank = RANK_FIELD_W'($urandom_range(0, 15));
        return rq;
    endfunction

    task automatic add_row(sset_mode_t m, logic [31:0] k, int r, bit fixed,
                           bit ok, bit full, logic [31:0] kout, int cnt);
        stim_row_t row;
        row.rq.mode          = m;
        row.rq.key           = k;
        row.rq.rank          = RANK_FIELD_W'(r);
        row.fixed            = fixed;
        row.want.success     = ok;
        row.want.full_res    = full;
        row.want.key_out     = kout;
        row.want.count       = COUNT_FIELD_W'(cnt);
        stim_tab.push_back(row);
    endtask

    // Offer one request after a gap and hold it until the transfer.
    task automatic send_op(sset_req_t rq, bit fixed, sset_rsp_t want, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= rq;
        offer_fixed     = fixed;
        offer_want      = want;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    // Check results first, then record the request taken at the same edge.
    always @(posedge clk)
    begin
        sset_rsp_t want;
        sset_rsp_t got;
        sset_rsp_t pred;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.payload;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result transfer: count %0d", got.count);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.success !== want.success)
                    begin
                        $error("success: expected %0b, got %0b", want.success, got.success);
                        mismatches++;
                    end
                    if (got.full_res !== want.full_res)
                    begin
                        $error("full_res: expected %0b, got %0b", want.full_res, got.full_res);
                        mismatches++;
                    end
                    if (got.key_out !== want.key_out)
                    begin
                        $error("key_out: expected %h, got %h", want.key_out, got.key_out);
                        mismatches++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        mismatches++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                pred = set_apply(req_ch.payload);
                pending_results.push_back(offer_fixed ? offer_want : pred);
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when asked for.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rcv_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rcv_hold--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        sset_rsp_t none;
        sset_req_t rq;
        bit        fill;
        int        phase_left;
        int        i;
        none           = '0;
        mismatches     = 0;
        calm           = 1'b0;
        rcv_hold       = 0;
        offer_fixed    = 1'b0;
        offer_want     = '0;
        set_count      = 0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        for (i = 0; i < CAP; i++)
            set_keys[i] = '0;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (i = 2; i < 24; i++)
            key_pool[i] = $urandom;

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty set, extremes of the key, duplicate insert, rank past the count
        add_row(MODE_GET,      32'h0,          0, 1, 0, 0, 32'h0,          0);
        add_row(MODE_ERASE,    32'h5,          0, 1, 0, 0, 32'h0,          0);
        add_row(MODE_INSERT,   32'hFFFF_FFFF,  0, 1, 1, 0, 32'h0,          1);
        add_row(MODE_INSERT,   32'h0,          0, 1, 1, 0, 32'h0,          2);
        add_row(MODE_INSERT,   32'h0,          0, 1, 0, 0, 32'h0,          2);
        add_row(MODE_GET,      32'h0,          1, 1, 1, 0, 32'hFFFF_FFFF,  2);
        add_row(MODE_GET,      32'h0,          2, 1, 0, 0, 32'h0,          2);
        // Fill to capacity
        for (i = 1; i <= 14; i++)
            add_row(MODE_INSERT, i * 32'h1111_1111, 15 - i, 0, 0, 0, 0, 0);
        // Full store: absent key refused, duplicate reported as duplicate, top rank read, top key erased
        add_row(MODE_INSERT,   32'h7,          0, 1, 0, 1, 32'h0,          16);
        add_row(MODE_INSERT,   32'h0,          0, 1, 0, 0, 32'h0,          16);
        add_row(MODE_GET,      32'h0,         15, 1, 1, 0, 32'hFFFF_FFFF,  16);
        add_row(MODE_CONTAINS, 32'h0,          0, 1, 1, 0, 32'h0,          16);
        add_row(MODE_ERASE,    32'hFFFF_FFFF,  0, 1, 1, 0, 32'h0,          15);
        add_row(MODE_GET,      32'h0,         15, 1, 0, 0, 32'h0,          15);
        add_row(MODE_CONTAINS, 32'h3333_3333,  7, 0, 0, 0, 0, 0);

        foreach (stim_tab[n])
            send_op(stim_tab[n].rq, stim_tab[n].fixed, stim_tab[n].want, pick_gap());

        fill       = 1'b0;
        phase_left = 0;
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (phase_left == 0)
            begin
                fill       = !fill;
                phase_left = $urandom_range(30, 90);
            end
            phase_left--;
            // Hold the result side off long enough to back up the request side
            if (i == 200)
                rcv_hold = 160;
            if (i == 400)
            begin
                drop_valid();
                while (pending_results.size() != 0)
                    @(posedge clk);
                repeat ($urandom_range(10, 30)) @(negedge clk);
            end
            calm = (i >= 500 && i < 560);
            rq = make_op(fill);
            send_op(rq, 1'b0, none, pick_gap());
        end
        drop_valid();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
